[sv/xyz_to_cielab_top_macros.svh]
// assertion macros for the xyz to cielab converter
// used by xyz_to_cielab_top, expects clk_i and rst_ni in scope
`ifndef XYZ_TO_CIELAB_TOP_MACROS_SVH
`define XYZ_TO_CIELAB_TOP_MACROS_SVH

// same-cycle implication
`define X2L_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define X2L_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/x2l_pkg.sv]
// shared types and constants of the xyz to cielab converter
// no dependencies
package x2l_pkg;

  localparam int DIV_STAGES  = 16;  // two quotient bits per stage
  localparam int CBRT_STAGES = 22;  // one root bit per stage
  localparam int LANE_LAT    = DIV_STAGES + 1 + CBRT_STAGES;
  localparam int F_W         = 22;
  localparam int LIN_W       = 14;

  localparam logic [31:0] EPS_Q16    = 32'd580;
  localparam logic [18:0] LIN_SLOPE  = 19'd510331;
  localparam logic [13:0] LIN_OFFSET = 14'd9039;
  localparam logic [25:0] KAPPA_Q24  = 26'd59198427;

  localparam logic [1:0] REG_WHITE_X = 2'd0;
  localparam logic [1:0] REG_WHITE_Y = 2'd1;
  localparam logic [1:0] REG_WHITE_Z = 2'd2;

  localparam logic [15:0] WHITE_X_RST = 16'd48664;
  localparam logic [15:0] WHITE_Y_RST = 16'd51200;
  localparam logic [15:0] WHITE_Z_RST = 16'd55748;

  typedef struct packed {
    logic [15:0] tri_x;
    logic [15:0] tri_y;
    logic [15:0] tri_z;
  } xyz_t;

  typedef struct packed {
    logic [15:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    logic               clipped;
  } lab_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_t;

endpackage

[sv/x2l_if.sv]
// valid/ready channel interfaces of the xyz to cielab converter
// depends on x2l_pkg
interface x2l_xyz_if;
  import x2l_pkg::*;
  logic valid;
  logic ready;
  xyz_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface x2l_lab_if;
  import x2l_pkg::*;
  logic valid;
  logic ready;
  lab_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface x2l_cfg_if;
  import x2l_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/xyz_to_cielab_top.sv]
// xyz to cielab converter, top level: white registers, three channel lanes, output math
// depends on x2l_pkg, x2l_if, x2l_lane and xyz_to_cielab_top_macros.svh
//
// Takes one xyz item per clock and returns one l*a*b* item for each, in order.
// From acceptance to output valid an item passes 16 stages of a radix-4
// restoring divider (sample / white), one stage for the region test and the
// linear branch of f, 22 stages of a bit-per-stage cube root, one stage of
// lightness and chroma products and the output register with saturation.
// The whole pipeline advances whenever the output register is empty or taken,
// so a full stream sustains one item per clock; a stall holds every stage.
// A white register of zero acts as one lsb. Configuration writes are always
// taken and must only happen while no item is in flight.
`include "xyz_to_cielab_top_macros.svh"

module xyz_to_cielab_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  x2l_cfg_if.sink   cfg_i,
  x2l_xyz_if.sink   xyz_i,
  x2l_lab_if.source lab_o
);
  import x2l_pkg::*;

  // white point registers
  logic [15:0] white_x_q, white_y_q, white_z_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= WHITE_X_RST;
      white_y_q <= WHITE_Y_RST;
      white_z_q <= WHITE_Z_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_WHITE_X: white_x_q <= cfg_i.data.data;
        REG_WHITE_Y: white_y_q <= cfg_i.data.data;
        REG_WHITE_Z: white_z_q <= cfg_i.data.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // global advance: the output slot is free or being emptied
  logic adv;
  logic out_vld_q;
  lab_t out_q;

  assign adv         = !out_vld_q || lab_o.ready;
  assign xyz_i.ready = adv;

  // valid bits ride along with the lanes plus the product stage
  logic [LANE_LAT:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LANE_LAT-1:0], xyz_i.valid};
      out_vld_q <= vld_q[LANE_LAT];
    end
  end

  // per channel ratio and f(t)
  logic [F_W-1:0] fx, fy, fz;
  logic [9:0]     ty_lo;
  logic           cube_y;
  logic [9:0]     tx_unused_lo, tz_unused_lo;
  logic           cube_x_unused, cube_z_unused;

  x2l_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (xyz_i.data.tri_x),
    .den_i  (white_x_q),
    .t_lo_o (tx_unused_lo),
    .cube_o (cube_x_unused),
    .f_o    (fx)
  );

  x2l_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (xyz_i.data.tri_y),
    .den_i  (white_y_q),
    .t_lo_o (ty_lo),
    .cube_o (cube_y),
    .f_o    (fy)
  );

  x2l_lane u_lane_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (xyz_i.data.tri_z),
    .den_i  (white_z_q),
    .t_lo_o (tz_unused_lo),
    .cube_o (cube_z_unused),
    .f_o    (fz)
  );

  // product stage: lightness before clamping, chroma before the rounding shift
  logic signed [24:0] lig_q;
  logic signed [31:0] a_pre_q, b_pre_q;
  logic signed [23:0] dxy, dyz;
  logic [31:0]        lig_cube;
  logic [35:0]        lig_lin;
  logic signed [24:0] lig_d;

  assign dxy      = $signed({2'b00, fx}) - $signed({2'b00, fy});
  assign dyz      = $signed({2'b00, fy}) - $signed({2'b00, fz});
  assign lig_cube = 32'(fy) * 32'd116 + 32'd128;
  assign lig_lin  = 36'(ty_lo) * 36'(KAPPA_Q24) + 36'd8388608;

  always_comb begin
    if (cube_y) begin
      lig_d = $signed({1'b0, lig_cube[31:8]}) - 25'sd4096;
    end else begin
      lig_d = $signed({13'h0, lig_lin[35:24]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lig_q   <= lig_d;
      a_pre_q <= 32'(dxy) * 32'sd125 + 32'sd128;
      b_pre_q <= 32'(dyz) * 32'sd25 + 32'sd64;
    end
  end

  // floor shifts and saturation into the output register
  logic signed [31:0] a_sh, b_sh;
  lab_t               out_d;

  assign a_sh = a_pre_q >>> 8;
  assign b_sh = b_pre_q >>> 7;

  always_comb begin
    out_d = '0;
    if (lig_q < 25'sd0) begin
      out_d.lightness = 16'h0000;
      out_d.clipped   = 1'b1;
    end else if (lig_q > 25'sd65535) begin
      out_d.lightness = 16'hFFFF;
      out_d.clipped   = 1'b1;
    end else begin
      out_d.lightness = lig_q[15:0];
    end
    if (a_sh > 32'sd32767) begin
      out_d.green_red = 16'sh7FFF;
      out_d.clipped   = 1'b1;
    end else if (a_sh < -32'sd32768) begin
      out_d.green_red = -16'sh8000;
      out_d.clipped   = 1'b1;
    end else begin
      out_d.green_red = a_sh[15:0];
    end
    if (b_sh > 32'sd32767) begin
      out_d.blue_yellow = 16'sh7FFF;
      out_d.clipped     = 1'b1;
    end else if (b_sh < -32'sd32768) begin
      out_d.blue_yellow = -16'sh8000;
      out_d.clipped     = 1'b1;
    end else begin
      out_d.blue_yellow = b_sh[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign lab_o.valid = out_vld_q;
  assign lab_o.data  = out_q;

  // checks
  `X2L_ASSERT_NEXT(a_last_stage_lands, adv && vld_q[LANE_LAT], lab_o.valid,
                   "finished item did not reach the output register")
  `X2L_ASSERT_NEXT(a_no_ghost, !(|vld_q) && !lab_o.valid, !lab_o.valid,
                   "output valid with an empty pipeline")
  `X2L_ASSERT_IMPL(a_clip_at_rail, lab_o.valid && lab_o.data.clipped,
                   lab_o.data.lightness == 16'h0000 || lab_o.data.lightness == 16'hFFFF ||
                   lab_o.data.green_red == 16'h7FFF || lab_o.data.green_red == 16'h8000 ||
                   lab_o.data.blue_yellow == 16'h7FFF || lab_o.data.blue_yellow == 16'h8000,
                   "clipped set without any output at a rail")

endmodule

[sv/x2l_lane.sv]
// one channel: pipelined ratio divider and pipelined cube root
// depends on x2l_pkg
module x2l_lane (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [15:0]             num_i,
  input  logic [15:0]             den_i,
  output logic [9:0]              t_lo_o,
  output logic                    cube_o,
  output logic [x2l_pkg::F_W-1:0] f_o
);
  import x2l_pkg::*;

  // divider stages
  logic [15:0] dv_rem_q [DIV_STAGES];
  logic [31:0] dv_acc_q [DIV_STAGES];
  logic [15:0] dv_den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [15:0] rem_in, rem_d;
    logic [31:0] acc_in, acc_d;
    logic [15:0] den_in, den_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = {num_i, 16'h0000};
      assign den_in = (den_i == 16'h0000) ? 16'h0001 : den_i;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign acc_in = dv_acc_q[k-1];
      assign den_in = dv_den_q[k-1];
    end

    always_comb begin
      logic [16:0] sh;
      rem_d = rem_in;
      acc_d = acc_in;
      den_d = den_in;
      for (int s = 0; s < 2; s++) begin
        sh    = {rem_d, acc_d[31]};
        acc_d = {acc_d[30:0], 1'b0};
        if (sh >= {1'b0, den_d}) begin
          rem_d    = 16'(sh - {1'b0, den_d});
          acc_d[0] = 1'b1;
        end else begin
          rem_d = sh[15:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k] <= rem_d;
        dv_acc_q[k] <= acc_d;
        dv_den_q[k] <= den_d;
      end
    end
  end

  // region test and linear branch of f
  logic [31:0]      pr_t_q;
  logic [LIN_W-1:0] pr_lin_q;
  logic             pr_cube_q;
  logic [29:0]      lin_rnd;
  logic [31:0]      t_div;

  assign t_div   = dv_acc_q[DIV_STAGES-1];
  assign lin_rnd = 30'(t_div[9:0]) * 30'(LIN_SLOPE) + 30'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_t_q    <= t_div;
      pr_lin_q  <= LIN_W'(lin_rnd[29:16]) + LIN_OFFSET;
      pr_cube_q <= (t_div > EPS_Q16);
    end
  end

  // digit-by-digit cube root of t * 2^32, squares kept incrementally
  logic [F_W-1:0]   cb_y_q    [CBRT_STAGES];
  logic [43:0]      cb_ysq_q  [CBRT_STAGES];
  logic [51:0]      cb_r_q    [CBRT_STAGES];
  logic [31:0]      cb_t_q    [CBRT_STAGES];
  logic [LIN_W-1:0] cb_lin_q  [CBRT_STAGES];
  logic             cb_cube_q [CBRT_STAGES];

  for (genvar j = 0; j < CBRT_STAGES; j++) begin : g_cbrt
    localparam int HI = 65 - 3 * j;
    logic [F_W-1:0]   y_in, y_d;
    logic [43:0]      ysq_in, ysq_d;
    logic [51:0]      r_in, r_sh, r_d, b;
    logic [31:0]      t_in;
    logic [LIN_W-1:0] lin_in;
    logic             cube_in;
    logic [65:0]      n;

    if (j == 0) begin : g_first
      assign y_in    = '0;
      assign ysq_in  = '0;
      assign r_in    = '0;
      assign t_in    = pr_t_q;
      assign lin_in  = pr_lin_q;
      assign cube_in = pr_cube_q;
    end else begin : g_next
      assign y_in    = cb_y_q[j-1];
      assign ysq_in  = cb_ysq_q[j-1];
      assign r_in    = cb_r_q[j-1];
      assign t_in    = cb_t_q[j-1];
      assign lin_in  = cb_lin_q[j-1];
      assign cube_in = cb_cube_q[j-1];
    end

    assign n    = {2'b00, t_in, 32'h0};
    assign r_sh = {r_in[48:0], n[HI -: 3]};
    assign b    = (52'(ysq_in) << 3) + (52'(ysq_in) << 2)
                + (52'(y_in) << 2) + (52'(y_in) << 1) + 52'd1;

    always_comb begin
      if (r_sh >= b) begin
        r_d   = r_sh - b;
        y_d   = {y_in[F_W-2:0], 1'b1};
        ysq_d = (ysq_in << 2) + (44'(y_in) << 2) + 44'd1;
      end else begin
        r_d   = r_sh;
        y_d   = {y_in[F_W-2:0], 1'b0};
        ysq_d = ysq_in << 2;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cb_y_q[j]    <= y_d;
        cb_ysq_q[j]  <= ysq_d;
        cb_r_q[j]    <= r_d;
        cb_t_q[j]    <= t_in;
        cb_lin_q[j]  <= lin_in;
        cb_cube_q[j] <= cube_in;
      end
    end
  end

  assign cube_o = cb_cube_q[CBRT_STAGES-1];
  assign t_lo_o = cb_t_q[CBRT_STAGES-1][9:0];
  assign f_o    = cube_o ? cb_y_q[CBRT_STAGES-1] : F_W'(cb_lin_q[CBRT_STAGES-1]);

endmodule
